[rtl/wsrc_pkg.sv]
// ----------------------------------------------------------------------------
// wsrc_pkg
// Shared types and constants of the work stealing range counter.
// ----------------------------------------------------------------------------
package wsrc_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned WORKER_W = 4;
  localparam int unsigned CNT_W    = 5;
  // workers that a scan may cover, set by the 4-bit worker and victim fields
  localparam int unsigned CNT_MAX  = 16;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEXT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] start_idx;
    logic [DATA_W-1:0] end_idx;
  } span_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_MOD,
    S_SCAN,
    S_DRAIN,
    S_SPLIT,
    S_FIX,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic eval;
    logic mod_sub;
    logic scan_init;
    logic scan_issue;
    logic steal_v;
    logic steal_w;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              cur_empty;
    logic              r_ge_cnt;
    logic              scan_last;
    logic              best_nonempty;
    logic              out_free;
  } dp_status_t;

endpackage

[rtl/wsrc_if.sv]
// ----------------------------------------------------------------------------
// wsrc_if
// Request and response channels of the work stealing range counter.
// ----------------------------------------------------------------------------
interface wsrc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  worker;
  logic [31:0] load_start;
  logic [31:0] load_end;

  modport source (output valid, func, worker, load_start, load_end, input ready);
  modport sink   (input valid, func, worker, load_start, load_end, output ready);
endinterface

interface wsrc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic [3:0]  victim;
  logic        range_empty;

  modport source (output valid, range_start, range_end, victim, range_empty, input ready);
  modport sink   (input valid, range_start, range_end, victim, range_empty, output ready);
endinterface

[rtl/work_stealing_range_counter_core.sv]
// ----------------------------------------------------------------------------
// work_stealing_range_counter_core
// Per-worker index range table with next, load and read and range stealing.
// ----------------------------------------------------------------------------
// Requests come in on req_i (valid/ready) carrying func, worker and, for a
// load, the range; every request gives one response on rsp_o. A load writes
// the worker's range and echoes it, a read returns it, a next returns the
// current range and bumps its start. An empty next scans the active workers
// in ring order from worker+1 and splits the largest range it finds.
// Load, read and non-empty next go from accept through lookup to emit. An empty
// next first reduces worker+1 modulo cnt, the active worker count, by repeated
// subtraction, then scans cnt entries, one table entry per cycle over the single
// memory read port, and takes an extra fix step only when it steals.
// One request is in flight at a time; a new one is taken while the previous
// response still sits in the output register.
// The worker count register is written over the APB port at address 0 (decoded
// from paddr[2] alone, so addresses 0 to 3); the user must write it only while
// idle, and the block itself does not enforce this.
// Reset clears the sequencer, the output valid and sets the worker count to 1;
// the range table is not cleared and must be loaded before use.
// If rsp_o stalls, the finished result waits in the sequencer's emit step.
// ----------------------------------------------------------------------------
module work_stealing_range_counter_core #(
  parameter int unsigned MAX_WORKERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsrc_req_if.sink    req_i,
  wsrc_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wsrc_pkg::*;

  localparam logic REG_NUM_WORKERS = 1'b0;

  logic [CNT_W-1:0] num_workers_q;
  logic             reg_sel;
  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic             req_ready;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_NUM_WORKERS) ? 32'(num_workers_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_workers_q <= CNT_W'(1);
    end else if (psel && penable && pwrite && reg_sel == REG_NUM_WORKERS) begin
      num_workers_q <= pwdata[CNT_W-1:0];
    end
  end

  wsrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign req_i.ready = req_ready;

  wsrc_dp #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .req_func_i        (req_i.func),
    .req_worker_i      (req_i.worker),
    .req_load_start_i  (req_i.load_start),
    .req_load_end_i    (req_i.load_end),
    .num_workers_i     (num_workers_q),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_range_start_o (rsp_o.range_start),
    .rsp_range_end_o   (rsp_o.range_end),
    .rsp_victim_o      (rsp_o.victim),
    .rsp_range_empty_o (rsp_o.range_empty)
  );

endmodule

[rtl/wsrc_ctrl.sv]
// ----------------------------------------------------------------------------
// wsrc_ctrl
// Sequencer: steps a request through lookup, ring start reduction, ring scan, split and emit.
// ----------------------------------------------------------------------------
module wsrc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  wsrc_pkg::dp_status_t   status_i,
  output wsrc_pkg::ctrl_cmd_t    cmd_o
);
  import wsrc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_CUR;
      end
      S_CUR: begin
        if (status_i.func == FUNC_NEXT && status_i.cur_empty) state_d = S_MOD;
        else state_d = S_EMIT;
      end
      S_MOD: begin
        if (!status_i.r_ge_cnt) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_SPLIT;
      S_SPLIT: begin
        if (status_i.best_nonempty) state_d = S_FIX;
        else state_d = S_EMIT;
      end
      S_FIX:  state_d = S_EMIT;
      S_EMIT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE:  cmd_o.take = req_valid_i;
      S_CUR:   cmd_o.eval = 1'b1;
      S_MOD: begin
        // reduce worker+1 modulo the active count, then start the ring
        if (status_i.r_ge_cnt) cmd_o.mod_sub = 1'b1;
        else cmd_o.scan_init = 1'b1;
      end
      S_SCAN:  cmd_o.scan_issue = 1'b1;
      S_DRAIN: cmd_o = '0;
      S_SPLIT: cmd_o.steal_v = status_i.best_nonempty;
      S_FIX:   cmd_o.steal_w = 1'b1;
      S_EMIT:  cmd_o.emit = status_i.out_free;
    endcase
  end

  a_take_to_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_CUR))
    else $error("accepted request did not move to lookup");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result emitted into a full output register");

  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ($past(state_q) == S_MOD || $past(state_q) == S_SCAN))
    else $error("scan entered without start index");

endmodule

[rtl/wsrc_dp.sv]
// ----------------------------------------------------------------------------
// wsrc_dp
// Datapath: range table memory, scan comparator, split logic, output register.
// ----------------------------------------------------------------------------
module wsrc_dp #(
  parameter int unsigned MAX_WORKERS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wsrc_pkg::ctrl_cmd_t             cmd_i,
  output wsrc_pkg::dp_status_t            status_o,
  input  logic [wsrc_pkg::FUNC_W-1:0]     req_func_i,
  input  logic [wsrc_pkg::WORKER_W-1:0]   req_worker_i,
  input  logic [wsrc_pkg::DATA_W-1:0]     req_load_start_i,
  input  logic [wsrc_pkg::DATA_W-1:0]     req_load_end_i,
  input  logic [wsrc_pkg::CNT_W-1:0]      num_workers_i,
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output logic [wsrc_pkg::DATA_W-1:0]     rsp_range_start_o,
  output logic [wsrc_pkg::DATA_W-1:0]     rsp_range_end_o,
  output logic [wsrc_pkg::WORKER_W-1:0]   rsp_victim_o,
  output logic                            rsp_range_empty_o
);
  import wsrc_pkg::*;

  localparam int unsigned IDX_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned LIM    = (MAX_WORKERS < CNT_MAX) ? MAX_WORKERS : CNT_MAX;
  localparam int unsigned CW     = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int unsigned WRAP_W = (IDX_W + 1 > WORKER_W) ? IDX_W + 1 : WORKER_W;

  // worker index modulo the table depth; at most eight subtractions
  function automatic logic [IDX_W-1:0] wrap_worker(input logic [WORKER_W-1:0] w);
    logic [WRAP_W-1:0] v;
    v = WRAP_W'(w);
    for (int n = 0; n < 8; n++) begin
      if (v >= WRAP_W'(MAX_WORKERS)) v = v - WRAP_W'(MAX_WORKERS);
    end
    return IDX_W'(v);
  endfunction

  span_t mem [MAX_WORKERS];
  span_t rd_q;

  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  w_q;
  logic [DATA_W-1:0] ld_start_q, ld_end_q;
  span_t             res_q;
  logic [IDX_W-1:0]  res_vic_q;
  span_t             best_q;
  logic [DATA_W-1:0] best_size_q;
  logic [IDX_W-1:0]  best_vic_q;
  logic [CW-1:0]     r_q;
  logic [CW-1:0]     scan_idx_q;
  logic [CNT_W-1:0]  k_q;
  logic              pipe_vld_q;
  logic [IDX_W-1:0]  pipe_idx_q;
  logic              out_vld_q;

  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] cand_size;
  logic              cand_better;
  logic [DATA_W-1:0] split;
  logic [CW-1:0]     scan_nxt;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  span_t             wdata;

  always_comb begin
    if (num_workers_i == '0) cnt = CNT_W'(1);
    else if (num_workers_i > CNT_W'(LIM)) cnt = CNT_W'(LIM);
    else cnt = num_workers_i;
  end

  assign cand_size   = (rd_q.start_idx < rd_q.end_idx) ? rd_q.end_idx - rd_q.start_idx : '0;
  assign cand_better = pipe_vld_q && (pipe_idx_q != w_q) && (cand_size > best_size_q);
  assign split       = best_q.start_idx + (best_size_q >> 1);
  assign scan_nxt    = (scan_idx_q + CW'(1) == CW'(cnt)) ? '0 : scan_idx_q + CW'(1);
  assign raddr       = cmd_i.take ? wrap_worker(req_worker_i) : IDX_W'(scan_idx_q);

  always_comb begin
    we    = 1'b0;
    waddr = w_q;
    wdata = rd_q;
    priority if (cmd_i.take && req_func_i == FUNC_LOAD) begin
      we    = 1'b1;
      waddr = wrap_worker(req_worker_i);
      wdata = '{start_idx: req_load_start_i, end_idx: req_load_end_i};
    end else if (cmd_i.eval && func_q == FUNC_NEXT) begin
      we    = 1'b1;
      wdata = '{start_idx: rd_q.start_idx + DATA_W'(1), end_idx: rd_q.end_idx};
    end else if (cmd_i.steal_v) begin
      // victim keeps the lower half
      we    = 1'b1;
      waddr = best_vic_q;
      wdata = '{start_idx: best_q.start_idx, end_idx: split};
    end else if (cmd_i.steal_w) begin
      we    = 1'b1;
      wdata = '{start_idx: res_q.start_idx + DATA_W'(1), end_idx: res_q.end_idx};
    end else begin
      we    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q     <= req_func_i;
      w_q        <= wrap_worker(req_worker_i);
      ld_start_q <= req_load_start_i;
      ld_end_q   <= req_load_end_i;
    end
    if (cmd_i.eval) begin
      if (func_q == FUNC_LOAD) res_q <= '{start_idx: ld_start_q, end_idx: ld_end_q};
      else res_q <= rd_q;
      res_vic_q   <= w_q;
      best_q      <= rd_q;
      best_size_q <= '0;
      best_vic_q  <= w_q;
      r_q         <= CW'(w_q) + CW'(1);
    end
    if (cmd_i.mod_sub) r_q <= r_q - CW'(cnt);
    if (cmd_i.scan_init) begin
      scan_idx_q <= r_q;
      k_q        <= '0;
    end
    if (cmd_i.scan_issue) begin
      scan_idx_q <= scan_nxt;
      k_q        <= k_q + CNT_W'(1);
      pipe_idx_q <= IDX_W'(scan_idx_q);
    end
    // first strictly larger entry wins
    if (cand_better) begin
      best_q      <= rd_q;
      best_size_q <= cand_size;
      best_vic_q  <= pipe_idx_q;
    end
    if (cmd_i.steal_v) begin
      res_q     <= '{start_idx: split, end_idx: best_q.end_idx};
      res_vic_q <= best_vic_q;
    end
    if (cmd_i.emit) begin
      rsp_range_start_o <= res_q.start_idx;
      rsp_range_end_o   <= res_q.end_idx;
      rsp_victim_o      <= WORKER_W'(res_vic_q);
      rsp_range_empty_o <= !(res_q.start_idx < res_q.end_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pipe_vld_q <= cmd_i.scan_issue;
      if (cmd_i.emit) out_vld_q <= 1'b1;
      else if (rsp_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign rsp_valid_o = out_vld_q;

  always_comb begin
    status_o.func          = func_q;
    status_o.cur_empty     = !(rd_q.start_idx < rd_q.end_idx);
    status_o.r_ge_cnt      = (r_q >= CW'(cnt));
    status_o.scan_last     = (k_q == cnt - CNT_W'(1));
    status_o.best_nonempty = (best_size_q != '0);
    status_o.out_free      = !out_vld_q || rsp_ready_i;
  end

  a_victim_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.steal_v |-> (best_vic_q != w_q && best_size_q != '0))
    else $error("steal from requester or from an empty range");

  a_scan_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_vld_q |-> (CW'(pipe_idx_q) < CW'(cnt)))
    else $error("scan index beyond active count");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=>
      (rsp_valid_o && $stable(rsp_range_start_o) && $stable(rsp_victim_o)))
    else $error("stalled response changed");

endmodule
